### rtl/c2ll_pkg.sv
// Shared types, widths and elaboration-time constants for the Cartesian to
// longitude / latitude converter. No dependencies; every rtl module but c2ll_delay imports it.

package c2ll_pkg;

  // Field widths of the item ports
  localparam int unsigned FRAME_W = 2;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned VEL_W   = 26;
  localparam int unsigned LON_W   = 22;
  localparam int unsigned LAT_W   = 21;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned STAT_W  = 2;

  // Internal datapath widths
  localparam int unsigned XY_W      = 60;  // CORDIC x / y, signed Q24
  localparam int unsigned ACC_W     = 48;  // angle accumulator, signed Q40 radians
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned K_W       = 32;  // CORDIC gain, Q30
  localparam int unsigned K_FRAC    = 30;
  localparam int unsigned SQ_W      = 63;  // root remainder / partial root
  localparam int unsigned DEG_W     = 28;  // rounded degree magnitude

  localparam int unsigned CORDIC_STAGES_DEF = 24;
  localparam int unsigned MAX_STAGES        = 32;

  localparam logic [FRAME_W-1:0] FRAME_EARTH_FIXED = 2'd1;

  localparam logic [39:0] DEG_E4_Q20 = 40'd600789792987;
  localparam logic [DEG_W-1:0] LON_LIMIT = DEG_W'(1800000);
  localparam logic [DEG_W-1:0] LAT_LIMIT = DEG_W'(900000);

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_FRAME = 2'd1,
    STATUS_NO_HORIZ  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  // Shift-subtract divide, used only to build constants
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q60 by the alternating series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv64(64'd1 << 60, n);
    nn  = n * n;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - t;
        else            sum = sum + t;
        p = udiv64(p, nn);
      end
    end
    return sum;
  endfunction

  // Stage angle atan(2^-i) in Q40, rounded half up from Q60
  function automatic logic signed [ACC_W-1:0] atan_q40(input int unsigned i);
    logic [63:0] v;
    if (i == 0) v = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    else        v = atan_recip(64'd1 << i);
    v = (v + (64'd1 << 19)) >> 20;
    return ACC_W'(v);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC gain in Q30 for n stages
  function automatic logic signed [K_W-1:0] gain_q30(input int unsigned n);
    logic [63:0] k2;
    k2 = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < n) k2 = k2 + (k2 >> (2 * i));
    end
    return K_W'(isqrt64(k2));
  endfunction

endpackage

### rtl/c2ll_cordic_cell.sv
// One vectoring stage of the CORDIC chain: rotate toward y = 0, add the angle.
// Depends on c2ll_pkg.

module c2ll_cordic_cell #(
  parameter int unsigned Index = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  c2ll_pkg::cordic_t data_i,
  output c2ll_pkg::cordic_t data_o
);
  import c2ll_pkg::*;

  localparam logic signed [ACC_W-1:0] Angle = atan_q40(Index);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  cordic_t data_d;
  cordic_t data_q;

  assign dx = data_i.y >>> Index;
  assign dy = data_i.x >>> Index;

  // turn clockwise while y is not negative
  always_comb begin
    if (!data_i.y[XY_W-1]) begin
      data_d.x   = data_i.x + dx;
      data_d.y   = data_i.y - dy;
      data_d.acc = data_i.acc + Angle;
    end else begin
      data_d.x   = data_i.x - dx;
      data_d.y   = data_i.y + dy;
      data_d.acc = data_i.acc - Angle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/c2ll_sqrt_cell.sv
// One result bit of the integer square root: trial subtract and shift.
// Depends on c2ll_pkg.

module c2ll_sqrt_cell #(
  parameter int unsigned Index = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  c2ll_pkg::sqrt_t data_i,
  output c2ll_pkg::sqrt_t data_o
);
  import c2ll_pkg::*;

  localparam logic [SQ_W-1:0] TrialBit = SQ_W'(1) << (62 - 2 * Index);

  logic [SQ_W-1:0] trial;
  sqrt_t data_d;
  sqrt_t data_q;

  assign trial = data_i.root + TrialBit;

  always_comb begin
    if (data_i.rem >= trial) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = (data_i.root >> 1) + TrialBit;
    end else begin
      data_d.rem  = data_i.rem;
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/c2ll_delay.sv
// Enabled shift line that aligns side data with the CORDIC chain.
// Standalone; no package needed.

module c2ll_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] line_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= data_i;
      for (int i = 1; i < Depth; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign data_o = line_q[Depth-1];

endmodule

### rtl/c2ll_deg_conv.sv
// Radians (Q40) to rounded 0.0001 degree magnitude plus sign, two stages.
// Depends on c2ll_pkg.

module c2ll_deg_conv (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [c2ll_pkg::ACC_W-1:0] acc_i,
  output logic [c2ll_pkg::DEG_W-1:0]        mag_o,
  output logic                              neg_o
);
  import c2ll_pkg::*;

  localparam int unsigned PROD_W = ACC_W + 40;

  logic [ACC_W-1:0] mag;
  logic [43:0] pll_q, plh_q, phl_q, phh_q;
  logic        neg_a_q;
  logic [PROD_W-1:0] prod;
  logic [DEG_W-1:0]  mag_q;
  logic              neg_q;

  assign mag = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);

  // split into 24 x 20 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= acc_i[ACC_W-1];
      pll_q   <= 44'(mag[23:0])  * 44'(DEG_E4_Q20[19:0]);
      plh_q   <= 44'(mag[23:0])  * 44'(DEG_E4_Q20[39:20]);
      phl_q   <= 44'(mag[47:24]) * 44'(DEG_E4_Q20[19:0]);
      phh_q   <= 44'(mag[47:24]) * 44'(DEG_E4_Q20[39:20]);
    end
  end

  // sum and round half up at bit 60
  assign prod = PROD_W'(pll_q) + (PROD_W'(plh_q) << 20) + (PROD_W'(phl_q) << 24)
              + (PROD_W'(phh_q) << 44) + (PROD_W'(1) << 59);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= neg_a_q;
      mag_q <= prod[PROD_W-1:60];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

### rtl/cartesian_to_lat_lon_converter_top.sv
// Top level of the Cartesian to longitude / latitude converter.
// Depends on c2ll_pkg, c2ll_cordic_cell, c2ll_sqrt_cell, c2ll_delay, c2ll_deg_conv.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one Earth-fixed state per item:
//   frame code, position in metres, velocity in mm/s. Output channel
//   (out_valid_o / out_ready_i) returns longitude and latitude in 0.0001 degree,
//   radius in metres, a northbound flag and a status code.
//   S = min(CORDIC_STAGES, 32). Throughput is one item per cycle while the
//   receiver does not stall; the two chains of S CORDIC cells (longitude, then
//   latitude) set the length of the pipe.
//   The radius runs through a chain of 32 square-root cells in parallel, and
//   the northbound test through a three-stage split multiply.
//   Reset clears only the stage valid bits; the pipe comes up empty.
//   When the receiver stalls, the whole pipe holds and in_ready_o drops; an
//   item is still taken in any cycle in which the waiting result leaves.

module cartesian_to_lat_lon_converter_top #(
  parameter int unsigned CORDIC_STAGES = c2ll_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [c2ll_pkg::FRAME_W-1:0]       frame_code_i,
  input  logic signed [c2ll_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [c2ll_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [c2ll_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [c2ll_pkg::VEL_W-1:0]  vel_x_i,
  input  logic signed [c2ll_pkg::VEL_W-1:0]  vel_y_i,
  input  logic signed [c2ll_pkg::VEL_W-1:0]  vel_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [c2ll_pkg::LON_W-1:0]  longitude_e4_o,
  output logic signed [c2ll_pkg::LAT_W-1:0]  latitude_e4_o,
  output logic [c2ll_pkg::RAD_W-1:0]         radius_m_o,
  output logic                               northbound_o,
  output logic [c2ll_pkg::STAT_W-1:0]        status_o
);
  import c2ll_pkg::*;

  localparam int unsigned Stages  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int unsigned Latency = 2 * Stages + 5;
  localparam int unsigned SqCells = 32;
  localparam int unsigned ZShift  = K_FRAC - FRAC_BITS;
  localparam logic signed [K_W-1:0]   GainQ30 = gain_q30(Stages);
  localparam logic signed [ACC_W-1:0] HalfPi  = ACC_W'(2 * atan_q40(0));
  localparam int unsigned ZK_W  = POS_W + K_W;
  localparam int unsigned DOT_W = POS_W + VEL_W + 1;
  localparam int unsigned NB_W  = 90;

  // Pipe control: advance when the output slot is free or being emptied
  logic adv;
  logic [Latency:1] valid_q;

  assign adv        = !valid_q[Latency] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Latency-1:1], in_valid_i};
    end
  end

  // Stage 1: capture the item
  logic [FRAME_W-1:0] frame1_q;
  logic signed [POS_W-1:0] x1_q, y1_q, z1_q;
  logic signed [VEL_W-1:0] vx1_q, vy1_q, vz1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frame1_q <= frame_code_i;
      x1_q     <= pos_x_i;
      y1_q     <= pos_y_i;
      z1_q     <= pos_z_i;
      vx1_q    <= vel_x_i;
      vy1_q    <= vel_y_i;
      vz1_q    <= vel_z_i;
    end
  end

  // Fault and axis flags, held until the output stage
  status_e status1;
  logic [STAT_W+1:0] flags1, flags_dly;

  always_comb begin
    priority if (frame1_q != FRAME_EARTH_FIXED) status1 = STATUS_BAD_FRAME;
    else if (x1_q == '0 && y1_q == '0)          status1 = STATUS_NO_HORIZ;
    else                                        status1 = STATUS_OK;
  end

  assign flags1 = {status1, (y1_q == '0), !x1_q[POS_W-1]};

  c2ll_delay #(.Width(STAT_W + 2), .Depth(2 * Stages + 3)) u_flags_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (flags1), .data_o (flags_dly)
  );

  // Stage 2: quadrant fold for the longitude pass, and the products
  logic signed [XY_W-1:0] xs1, ys1;
  cordic_t lon_init_q;
  logic [2*POS_W-2:0] xx2_q, yy2_q, zz2_q;
  logic signed [POS_W+VEL_W-1:0] xvx2_q, yvy2_q;
  logic signed [ZK_W-1:0] zk2_q;
  logic signed [POS_W-1:0] z2_q;
  logic signed [VEL_W-1:0] vz2_q;

  assign xs1 = XY_W'(x1_q) <<< FRAC_BITS;
  assign ys1 = XY_W'(y1_q) <<< FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // turn a left-half vector by 90 degrees first
      if (x1_q[POS_W-1]) begin
        if (!y1_q[POS_W-1]) begin
          lon_init_q <= '{x: ys1, y: -xs1, acc: HalfPi};
        end else begin
          lon_init_q <= '{x: -ys1, y: xs1, acc: -HalfPi};
        end
      end else begin
        lon_init_q <= '{x: xs1, y: ys1, acc: '0};
      end
      xx2_q  <= (2*POS_W-1)'(64'(x1_q) * 64'(x1_q));
      yy2_q  <= (2*POS_W-1)'(64'(y1_q) * 64'(y1_q));
      zz2_q  <= (2*POS_W-1)'(64'(z1_q) * 64'(z1_q));
      xvx2_q <= (POS_W+VEL_W)'(x1_q) * (POS_W+VEL_W)'(vx1_q);
      yvy2_q <= (POS_W+VEL_W)'(y1_q) * (POS_W+VEL_W)'(vy1_q);
      zk2_q  <= ZK_W'(z1_q) * ZK_W'(GainQ30);
      z2_q   <= z1_q;
      vz2_q  <= vz1_q;
    end
  end

  // Stage 3: sums
  logic [SQ_W-2:0] hsq3_q;
  logic [SQ_W-1:0] r2_3_q;
  logic signed [DOT_W-1:0] dot3_q;
  logic signed [POS_W-1:0] z3_q;
  logic signed [VEL_W-1:0] vz3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hsq3_q <= (SQ_W-1)'(xx2_q) + (SQ_W-1)'(yy2_q);
      r2_3_q <= SQ_W'(xx2_q) + SQ_W'(yy2_q) + SQ_W'(zz2_q);
      dot3_q <= DOT_W'(xvx2_q) + DOT_W'(yvy2_q);
      z3_q   <= z2_q;
      vz3_q  <= vz2_q;
    end
  end

  // Northbound: sign of vz*hsq - z*dot, split multiply over stages 4 to 6
  logic signed [57:0] pa_l4_q, pa_h4_q;
  logic signed [60:0] pb_l4_q;
  logic signed [59:0] pb_h4_q;
  logic signed [NB_W-1:0] a5_q, b5_q, diff5;
  logic nb6_q, nb_dly;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_l4_q <= 58'(vz3_q) * 58'($signed({1'b0, hsq3_q[30:0]}));
      pa_h4_q <= 58'(vz3_q) * 58'($signed({1'b0, hsq3_q[61:31]}));
      pb_l4_q <= 61'(z3_q) * 61'($signed({1'b0, dot3_q[28:0]}));
      pb_h4_q <= 60'(z3_q) * 60'($signed(dot3_q[DOT_W-1:29]));
      a5_q    <= (NB_W'(pa_h4_q) <<< 31) + NB_W'(pa_l4_q);
      b5_q    <= (NB_W'(pb_h4_q) <<< 29) + NB_W'(pb_l4_q);
      nb6_q   <= !diff5[NB_W-1];
    end
  end

  assign diff5 = a5_q - b5_q;

  c2ll_delay #(.Width(1), .Depth(2 * Stages - 2)) u_nb_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (nb6_q), .data_o (nb_dly)
  );

  // Radius: square-root cell chain, then round to nearest
  sqrt_t sq_c [SqCells+1];
  logic [SQ_W-1:0] rad_full;
  logic [RAD_W-1:0] rad_dly;

  assign sq_c[0] = '{rem: r2_3_q, root: '0};

  for (genvar k = 0; k < SqCells; k++) begin : g_sqrt
    c2ll_sqrt_cell #(.Index(k)) u_cell (
      .clk_i (clk_i), .en_i (adv), .data_i (sq_c[k]), .data_o (sq_c[k+1])
    );
  end

  assign rad_full = sq_c[SqCells].root + SQ_W'(sq_c[SqCells].rem > sq_c[SqCells].root);

  c2ll_delay #(.Width(RAD_W), .Depth(2 * Stages - 31)) u_rad_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (rad_full[RAD_W-1:0]), .data_o (rad_dly)
  );

  // Longitude CORDIC chain
  cordic_t lon_c [Stages+1];

  assign lon_c[0] = lon_init_q;

  for (genvar k = 0; k < Stages; k++) begin : g_lon
    c2ll_cordic_cell #(.Index(k)) u_cell (
      .clk_i (clk_i), .en_i (adv), .data_i (lon_c[k]), .data_o (lon_c[k+1])
    );
  end

  // Latitude CORDIC chain on (horizontal magnitude, z scaled by the gain)
  logic [ZK_W-1:0] zk_dly;
  logic signed [ZK_W-1:0] zk_s;
  cordic_t lat_c [Stages+1];

  c2ll_delay #(.Width(ZK_W), .Depth(Stages)) u_zk_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (zk2_q), .data_o (zk_dly)
  );

  assign zk_s     = $signed(zk_dly);
  assign lat_c[0] = '{x: lon_c[Stages].x, y: XY_W'(zk_s >>> ZShift), acc: '0};

  for (genvar k = 0; k < Stages; k++) begin : g_lat
    c2ll_cordic_cell #(.Index(k)) u_cell (
      .clk_i (clk_i), .en_i (adv), .data_i (lat_c[k]), .data_o (lat_c[k+1])
    );
  end

  // Angle to degrees; the longitude result waits for the latitude pass
  logic [DEG_W-1:0] lon_mag, lat_mag;
  logic lon_neg, lat_neg;
  logic [DEG_W:0] lon_conv, lon_dly;

  c2ll_deg_conv u_lon_conv (
    .clk_i (clk_i), .en_i (adv), .acc_i (lon_c[Stages].acc),
    .mag_o (lon_conv[DEG_W-1:0]), .neg_o (lon_conv[DEG_W])
  );

  c2ll_delay #(.Width(DEG_W + 1), .Depth(Stages)) u_lon_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (lon_conv), .data_o (lon_dly)
  );

  assign lon_mag = lon_dly[DEG_W-1:0];
  assign lon_neg = lon_dly[DEG_W];

  c2ll_deg_conv u_lat_conv (
    .clk_i (clk_i), .en_i (adv), .acc_i (lat_c[Stages].acc),
    .mag_o (lat_mag), .neg_o (lat_neg)
  );

  // Output stage: clamp, axis and fault cases
  status_e status_f;
  logic y_zero_f, x_pos_f;
  logic [DEG_W-1:0] lon_lim, lat_lim;
  logic signed [LON_W-1:0] lon_d, lon_q;
  logic signed [LAT_W-1:0] lat_d, lat_q;
  logic [RAD_W-1:0] rad_d, rad_q;
  logic nb_d, nb_q;
  logic [STAT_W-1:0] stat_q;

  assign status_f = status_e'(flags_dly[STAT_W+1:2]);
  assign y_zero_f = flags_dly[1];
  assign x_pos_f  = flags_dly[0];
  assign lon_lim  = (lon_mag > LON_LIMIT) ? LON_LIMIT : lon_mag;
  assign lat_lim  = (lat_mag > LAT_LIMIT) ? LAT_LIMIT : lat_mag;

  always_comb begin
    lon_d = lon_neg ? -LON_W'(lon_lim) : LON_W'(lon_lim);
    lat_d = lat_neg ? -LAT_W'(lat_lim) : LAT_W'(lat_lim);
    rad_d = rad_dly;
    nb_d  = nb_dly;
    if (status_f != STATUS_OK) begin
      // zero every field of a faulted item but its status
      lon_d = '0;
      lat_d = '0;
      rad_d = '0;
      nb_d  = 1'b0;
    end else if (y_zero_f) begin
      lon_d = x_pos_f ? '0 : LON_W'(LON_LIMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lon_q  <= lon_d;
      lat_q  <= lat_d;
      rad_q  <= rad_d;
      nb_q   <= nb_d;
      stat_q <= status_f;
    end
  end

  assign out_valid_o    = valid_q[Latency];
  assign longitude_e4_o = lon_q;
  assign latitude_e4_o  = lat_q;
  assign radius_m_o     = rad_q;
  assign northbound_o   = nb_q;
  assign status_o       = stat_q;

  // A faulted item carries nothing but its status
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |->
      longitude_e4_o == '0 && latitude_e4_o == '0 && radius_m_o == '0 && !northbound_o)
    else $error("faulted item with nonzero fields");

  // Angles stay inside their clamp limits
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      longitude_e4_o <= $signed(LON_W'(LON_LIMIT)) &&
      longitude_e4_o >= -$signed(LON_W'(LON_LIMIT)) &&
      latitude_e4_o <= $signed(LAT_W'(LAT_LIMIT)) &&
      latitude_e4_o >= -$signed(LAT_W'(LAT_LIMIT)))
    else $error("angle outside its range");

  // A good item has a nonzero horizontal radius, so a nonzero distance
  a_radius_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |-> radius_m_o != '0)
    else $error("zero radius on a good item");

endmodule

### tb/sv/cartesian_to_lat_lon_converter_top_test.sv
// Self-checking testbench for cartesian_to_lat_lon_converter_top.
// Depends on c2ll_pkg and the rtl; predicts each result with its own CORDIC model.

module cartesian_to_lat_lon_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import c2ll_pkg::*;

  localparam int unsigned STAGES    = 24;
  localparam int unsigned STAGES_IN = (STAGES > 32) ? 32 : STAGES;
  localparam int unsigned LATENCY   = 2 * STAGES_IN + 5;
  localparam int          RAND_ITEMS = 1725;
  localparam longint      LON_MAX   = 1800000;
  localparam longint      LAT_MAX   = 900000;

  // One Earth-fixed state as it enters the block
  typedef struct {
    logic [FRAME_W-1:0]       frame;
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [VEL_W-1:0]  vx, vy, vz;
  } state_t;

  // One geodetic result as it leaves the block
  typedef struct {
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] lat;
    logic [RAD_W-1:0]        rad;
    logic                    north;
    status_e                 status;
  } geo_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FRAME_W-1:0]       frame_code = '0;
  logic signed [POS_W-1:0]  pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [VEL_W-1:0]  vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [LON_W-1:0]  longitude_e4;
  logic signed [LAT_W-1:0]  latitude_e4;
  logic [RAD_W-1:0]         radius_m;
  logic                     northbound;
  logic [STAT_W-1:0]        status;

  state_t pending_states[$];
  geo_t   expected_geo[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     mismatches    = 0;
  int     results_seen  = 0;
  int     status_seen[4] = '{default: 0};

  longint stage_angle[32];  // atan(2^-i), Q40 radians
  longint gain_q30;         // CORDIC gain, Q30

  cartesian_to_lat_lon_converter_top #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .frame_code_i(frame_code),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .vel_x_i(vel_x), .vel_y_i(vel_y), .vel_z_i(vel_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .longitude_e4_o(longitude_e4), .latitude_e4_o(latitude_e4),
    .radius_m_o(radius_m), .northbound_o(northbound), .status_o(status)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // atan(1/n) in Q60 from the alternating power series
  function automatic longint unsigned arctan_inv_q60(longint unsigned n);
    longint unsigned p, nn, total, k, t;
    p = (64'd1 << 60) / n;
    nn = n * n;
    total = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) total -= t;
      else total += t;
      p = p / nn;
      k++;
    end
    return total;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Drive y toward zero; return the summed angle and the final x
  function automatic longint vector_to_axis(longint x, longint y, longint ang,
                                            output longint x_end);
    longint dx, dy;
    for (int i = 0; i < STAGES_IN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        ang += stage_angle[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= stage_angle[i];
      end
    end
    x_end = x;
    return ang;
  endfunction

  // Q40 radians to 0.0001 degree, rounded half away from zero
  function automatic longint radians_to_deg_e4(longint ang);
    logic [127:0] prod;
    longint unsigned mag;
    longint r;
    mag = (ang < 0) ? -ang : ang;
    prod = {64'd0, mag} * {88'd0, DEG_E4_Q20};
    prod += 128'd1 << 59;
    r = longint'(prod >> 60);
    return (ang < 0) ? -r : r;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic geo_t convert_state(state_t s);
    geo_t g;
    longint x, y, z, vx, vy, vz, cx, cy, ang, x_end, x_unused, lon, lat, half_pi;
    longint unsigned hsq, r2, r;
    logic signed [127:0] lhs, rhs;
    g.lon = '0;
    g.lat = '0;
    g.rad = '0;
    g.north = 1'b0;
    x = longint'(s.px); y = longint'(s.py); z = longint'(s.pz);
    vx = longint'(s.vx); vy = longint'(s.vy); vz = longint'(s.vz);
    if (s.frame != FRAME_EARTH_FIXED) begin
      g.status = STATUS_BAD_FRAME;
      return g;
    end
    if (x == 0 && y == 0) begin
      g.status = STATUS_NO_HORIZ;
      return g;
    end
    g.status = STATUS_OK;
    half_pi = 2 * stage_angle[0];
    // Fold the left half plane into the right one by a quarter turn
    cx = x <<< FRAC_BITS;
    cy = y <<< FRAC_BITS;
    ang = 0;
    if (cx < 0) begin
      if (cy >= 0) begin
        ang = half_pi;
        cy = -cx;
        cx = y <<< FRAC_BITS;
      end else begin
        ang = -half_pi;
        cy = cx;
        cx = -(y <<< FRAC_BITS);
      end
    end
    ang = vector_to_axis(cx, cy, ang, x_end);
    if (y == 0) lon = (x > 0) ? 0 : LON_MAX;
    else lon = clip(radians_to_deg_e4(ang), LON_MAX);
    // z is scaled by the gain so it matches the grown horizontal magnitude
    ang = vector_to_axis(x_end, (z * gain_q30) >>> (K_FRAC - FRAC_BITS), 0, x_unused);
    lat = clip(radians_to_deg_e4(ang), LAT_MAX);
    hsq = longint'(x * x) + longint'(y * y);
    r2 = hsq + longint'(z * z);
    r = int_sqrt(r2);
    if (r2 - r * r > r) r++;
    // Sign of vz*rh^2 - z*(x*vx + y*vy), exact in 128 bits
    lhs = 128'(vz);
    lhs = lhs * $signed({64'd0, hsq});
    rhs = 128'(z);
    rhs = rhs * (x * vx + y * vy);
    g.lon = lon[LON_W-1:0];
    g.lat = lat[LAT_W-1:0];
    g.rad = r[RAD_W-1:0];
    g.north = !((lhs - rhs) < 0);
    return g;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // Advance only once the current item is taken; otherwise hold it
      if (pending_states.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        state_t s;
        s = pending_states.pop_front();
        in_valid   <= 1'b1;
        frame_code <= s.frame;
        pos_x <= s.px; pos_y <= s.py; pos_z <= s.pz;
        vel_x <= s.vx; vel_y <= s.vy; vel_z <= s.vz;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      // Predict each accepted item at the edge that takes it
      if (in_valid && in_ready) begin
        state_t s;
        s.frame = frame_code;
        s.px = pos_x; s.py = pos_y; s.pz = pos_z;
        s.vx = vel_x; s.vy = vel_y; s.vz = vel_z;
        expected_geo.push_back(convert_state(s));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        status_seen[status]++;
        if (expected_geo.size() == 0) begin
          report_mismatch("unexpected result, status", status, -1);
        end else begin
          geo_t g;
          g = expected_geo.pop_front();
          if (longitude_e4 !== g.lon) report_mismatch("longitude", longitude_e4, g.lon);
          if (latitude_e4 !== g.lat) report_mismatch("latitude", latitude_e4, g.lat);
          if (radius_m !== g.rad) report_mismatch("radius", radius_m, g.rad);
          if (northbound !== g.north) report_mismatch("northbound", northbound, g.north);
          if (status !== g.status) report_mismatch("status", status, g.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [POS_W-1:0] pick_pos();
    case ($urandom_range(9))
      0, 1:    return POS_W'($urandom());
      2:       return POS_W'($signed($urandom_range(2000)) - 1000);
      3:       return '0;
      default: return POS_W'($signed($urandom_range(84_000_000)) - 42_000_000);
    endcase
  endfunction

  function automatic logic signed [VEL_W-1:0] pick_vel();
    case ($urandom_range(5))
      0:       return VEL_W'($urandom());
      1:       return '0;
      default: return VEL_W'($signed($urandom_range(16_000_000)) - 8_000_000);
    endcase
  endfunction

  function automatic state_t make_state(logic [FRAME_W-1:0] f,
                                        longint x, longint y, longint z,
                                        longint vx, longint vy, longint vz);
    state_t s;
    s.frame = f;
    s.px = POS_W'(x); s.py = POS_W'(y); s.pz = POS_W'(z);
    s.vx = VEL_W'(vx); s.vy = VEL_W'(vy); s.vz = VEL_W'(vz);
    return s;
  endfunction

  task automatic drain();
    while (pending_states.size() > 0 || in_valid || expected_geo.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    longint pmax, pmin, vmax, vmin;
    state_t s;
    pmax = 1073741823; pmin = -1073741824;
    vmax = 33554431;   vmin = -33554432;
    stage_angle[0] = (4 * arctan_inv_q60(5) - arctan_inv_q60(239) + (64'd1 << 19)) >> 20;
    for (int i = 1; i < 32; i++)
      stage_angle[i] = (arctan_inv_q60(64'd1 << i) + (64'd1 << 19)) >> 20;
    begin
      longint unsigned k2;
      k2 = 64'd1 << 60;
      for (int i = 0; i < STAGES_IN; i++) k2 += k2 >> (2 * i);
      gain_q30 = int_sqrt(k2);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: frames, degenerate axes, field extremes
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pending_states.push_back(make_state(0, 7000000, 0, 0, 0, 0, 0));
    pending_states.push_back(make_state(2, 7000000, 1, 1, 1, 1, 1));
    pending_states.push_back(make_state(3, pmin, pmax, pmin, vmin, vmax, vmin));
    pending_states.push_back(make_state(1, 0, 0, 6371000, 1000, 0, 0));
    pending_states.push_back(make_state(1, 0, 0, pmin, vmax, vmax, vmax));
    pending_states.push_back(make_state(1, 6371000, 0, 0, 0, 7500000, 0));
    pending_states.push_back(make_state(1, -6371000, 0, 0, 0, -7500000, 0));
    pending_states.push_back(make_state(1, pmin, 0, pmax, vmin, vmin, vmin));
    pending_states.push_back(make_state(1, 0, 6371000, 100, 0, 0, 7000));
    pending_states.push_back(make_state(1, 0, -6371000, -100, 0, 0, -7000));
    pending_states.push_back(make_state(1, pmax, pmax, pmax, vmax, vmax, vmax));
    pending_states.push_back(make_state(1, pmin, pmin, pmin, vmin, vmin, vmin));
    pending_states.push_back(make_state(1, pmin, pmax, 0, vmax, vmin, 0));
    pending_states.push_back(make_state(1, pmax, pmin, pmin, vmin, vmax, vmax));
    pending_states.push_back(make_state(1, -5000000, -4000000, 3000000, 100, -200, 300));
    pending_states.push_back(make_state(1, 1, 1, 1, 1, 1, 1));
    pending_states.push_back(make_state(1, -1, 0, 0, 0, 0, 0));
    pending_states.push_back(make_state(1, 1, -1, 1, 0, 0, 0));
    pending_states.push_back(make_state(1, 4000000, 3000000, pmax, 0, 0, 0));
    pending_states.push_back(make_state(1, 4000000, -3000000, pmin, 5, 5, -5));
    pending_states.push_back(make_state(1, -1, pmax, 0, 0, 0, 0));
    pending_states.push_back(make_state(1, -1, pmin, 1, 0, 0, 1));
    pending_states.push_back(make_state(1, 42164000, 0, 1, 0, 3074600, 0));
    drain();

    // Random: mostly Earth-fixed states, some wrong frames, three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        s.frame = ($urandom_range(9) == 0) ? FRAME_W'($urandom()) : FRAME_EARTH_FIXED;
        s.px = pick_pos(); s.py = pick_pos(); s.pz = pick_pos();
        s.vx = pick_vel(); s.vy = pick_vel(); s.vz = pick_vel();
        pending_states.push_back(s);
      end
      drain();
    end

    // Let any stray result surface
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Checked %0d results: %0d ok, %0d wrong frame, %0d on the polar axis",
             results_seen, status_seen[STATUS_OK], status_seen[STATUS_BAD_FRAME],
             status_seen[STATUS_NO_HORIZ]);
    $display("Idling mixes: sender-light, receiver-light, none; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_geo.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", expected_geo.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/c2ll_pkg.sv
rtl/c2ll_cordic_cell.sv
rtl/c2ll_sqrt_cell.sv
rtl/c2ll_delay.sv
rtl/c2ll_deg_conv.sv
rtl/cartesian_to_lat_lon_converter_top.sv
tb/sv/cartesian_to_lat_lon_converter_top_test.sv
